// ===== hw/rtl/mme_pkg.sv =====
package mme_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
    localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 5'd16;

    // input action codes
    localparam logic [1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    // fixed point
    localparam int FRAC_BITS  = 12;
    localparam int RND_HALF   = 1 << (FRAC_BITS - 1);
    localparam int RESULT_MAX = 32767;
    localparam int RESULT_MIN = -32768;

    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int RES_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] value;
    } item_t;

    typedef struct packed {
        logic [3:0]         out_row;
        logic [3:0]         out_col;
        logic signed [15:0] result;
        logic               status;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] rows_a;
        logic [CFG_DATA_W-1:0] inner_len;
        logic [CFG_DATA_W-1:0] cols_b;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_COMPUTE,
        CMD_ROW_ERR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DRAIN,
        BK_PUSH
    } back_state_t;

endpackage

// ===== hw/rtl/matrix_multiply_engine.sv =====
// channel   | handshake            | payload  | beat
// ----------+----------------------+----------+--------------------------------------
// items     | push / full          | item     | load A, load B or compute one row
// results   | pop / empty          | res      | one output element, last marks row end
// config    | wr_en                | wr_index, wr_data | one register write
//
// the front takes an item every cycle while its 4-entry command queue has room
// load: one memory write in the back end's idle state; row error: one beat pushed from idle
// compute: each output column in turn through the single shared
// multiply-accumulate unit and the one read port of each element memory
// reset sets all three registers to 16 and empties both queues; element
// memories are not cleared and must be loaded before use
// a full result queue stalls the back end only; the front keeps queuing
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM   = 16,
    parameter int ELEM_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic                  push,
    input  item_t                 item,
    output logic                  full,
    input  logic                  pop,
    output res_t                  res,
    output logic                  empty
);
    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    logic cmd_empty, cmd_pop;
    logic res_full, res_push;
    res_t res_data;
    logic [$bits(res_t)-1:0] res_vec;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_ROWS_A:    cfg_next.rows_a    = wr_data;
                CFG_INNER_LEN: cfg_next.inner_len = wr_data;
                CFG_COLS_B:    cfg_next.cols_b    = wr_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows_a    <= CFG_DIM_RESET;
            cfg_reg.inner_len <= CFG_DIM_RESET;
            cfg_reg.cols_b    <= CFG_DIM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mme_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop)
    );

    mme_back #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    mme_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_vec),
        .empty (empty)
    );

    assign res = res_t'(res_vec);

endmodule

// ===== hw/rtl/mme_fifo.sv =====
module mme_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/mme_front.sv =====
module mme_front
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  push,
    input  item_t item,
    output logic  full,
    output cmd_t  cmd,
    output logic  cmd_empty,
    input  logic  cmd_pop
);
    logic [CFG_DATA_W-1:0] rows_eff;
    logic                  in_range;
    logic                  keep;
    cmd_t                  cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_vec;

    assign rows_eff = (cfg.rows_a > CFG_DATA_W'(MAX_DIM)) ? CFG_DATA_W'(MAX_DIM) : cfg.rows_a;
    assign in_range = ({1'b0, item.row} < CFG_DATA_W'(MAX_DIM)) &&
                      ({1'b0, item.col} < CFG_DATA_W'(MAX_DIM));

    // drop beats that leave no trace: unused action, loads outside the store
    always_comb
    begin
        cmd_in.row   = item.row;
        cmd_in.col   = item.col;
        cmd_in.value = item.value;
        cmd_in.kind  = CMD_LOAD_A;
        keep         = 1'b0;
        case (item.action)
            ACT_LOAD_A:
            begin
                cmd_in.kind = CMD_LOAD_A;
                keep        = in_range;
            end
            ACT_LOAD_B:
            begin
                cmd_in.kind = CMD_LOAD_B;
                keep        = in_range;
            end
            ACT_COMPUTE:
            begin
                cmd_in.kind = ({1'b0, item.row} >= rows_eff) ? CMD_ROW_ERR : CMD_COMPUTE;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    mme_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_vec),
        .empty (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_vec);

endmodule

// ===== hw/rtl/mme_back.sv =====
module mme_back
    import mme_pkg::*;
#(
    parameter int MAX_DIM   = 16,
    parameter int ELEM_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  cmd_t cmd,
    input  logic cmd_empty,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res_data
);
    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int ACC_W  = PROD_W + CNT_W;
    localparam int SUM_W  = (ACC_W > 30) ? ACC_W + 1 : 31;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(RESULT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(RESULT_MIN);

    logic signed [ELEM_BITS-1:0] a_mem [MAX_DIM * MAX_DIM];
    logic signed [ELEM_BITS-1:0] b_mem [MAX_DIM * MAX_DIM];

    back_state_t state_reg, state_next;
    logic [3:0]       row_reg;
    logic [CNT_W-1:0] nk_reg, nc_reg, k_reg, j_reg;
    logic             s1_vld_reg, s2_vld_reg;
    logic signed [ELEM_BITS-1:0] a_rd_reg, b_rd_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;

    logic [CNT_W-1:0]  nk_eff, nc_eff;
    logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;
    logic signed [ELEM_BITS-1:0] elem;
    logic signed [SUM_W-1:0]     sum, shifted;
    logic signed [15:0]          rounded;
    logic have_cmd, start, issue, col_done, a_we, b_we, last_col;

    assign nk_eff = (cfg.inner_len > CFG_DATA_W'(MAX_DIM)) ? CNT_W'(MAX_DIM)
                                                           : CNT_W'(cfg.inner_len);
    assign nc_eff = (cfg.cols_b > CFG_DATA_W'(MAX_DIM)) ? CNT_W'(MAX_DIM)
                                                        : CNT_W'(cfg.cols_b);

    assign wr_addr   = ADDR_W'(cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col);
    assign a_rd_addr = ADDR_W'(row_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg[DIM_W-1:0]);
    assign b_rd_addr = ADDR_W'(k_reg[DIM_W-1:0]) * ADDR_W'(MAX_DIM)
                     + ADDR_W'(j_reg[DIM_W-1:0]);

    generate
        if (ELEM_BITS >= 16)
        begin : g_elem_wide
            assign elem = ELEM_BITS'(cmd.value);
        end
        else
        begin : g_elem_sat
            localparam logic signed [15:0] EL_HI = 16'((1 << (ELEM_BITS - 1)) - 1);
            localparam logic signed [15:0] EL_LO = ~EL_HI;
            always_comb
            begin
                if (cmd.value > EL_HI)
                begin
                    elem = EL_HI[ELEM_BITS-1:0];
                end
                else if (cmd.value < EL_LO)
                begin
                    elem = EL_LO[ELEM_BITS-1:0];
                end
                else
                begin
                    elem = cmd.value[ELEM_BITS-1:0];
                end
            end
        end
    endgenerate

    // round half up, floor shift, saturate
    assign sum     = SUM_W'(acc_reg) + SUM_W'(RND_HALF);
    assign shifted = sum >>> FRAC_BITS;
    assign rounded = (shifted > SAT_HI) ? 16'(RESULT_MAX) :
                     (shifted < SAT_LO) ? 16'(RESULT_MIN) : shifted[15:0];

    assign have_cmd = (state_reg == BK_IDLE) && !cmd_empty;
    assign last_col = ((j_reg + CNT_W'(1)) == nc_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (have_cmd && (cmd.kind == CMD_COMPUTE) && (nc_eff != '0))
                begin
                    state_next = (nk_eff == '0) ? BK_DRAIN : BK_READ;
                end
            end
            BK_READ:
            begin
                if ((k_reg + CNT_W'(1)) == nk_reg)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = BK_PUSH;
                end
            end
            BK_PUSH:
            begin
                if (!res_full)
                begin
                    if (last_col)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        state_next = (nk_reg == '0) ? BK_DRAIN : BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop  = 1'b0;
        res_push = 1'b0;
        a_we     = 1'b0;
        b_we     = 1'b0;
        start    = 1'b0;
        issue    = 1'b0;
        col_done = 1'b0;
        res_data.out_row = row_reg;
        res_data.out_col = 4'(j_reg);
        res_data.result  = rounded;
        res_data.status  = 1'b0;
        res_data.last    = last_col;
        case (state_reg)
            BK_IDLE:
            begin
                if (have_cmd)
                begin
                    case (cmd.kind)
                        CMD_LOAD_A:
                        begin
                            a_we    = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        CMD_LOAD_B:
                        begin
                            b_we    = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        CMD_COMPUTE:
                        begin
                            start   = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        default:
                        begin
                            res_data.out_row = cmd.row;
                            res_data.out_col = '0;
                            res_data.result  = '0;
                            res_data.status  = 1'b1;
                            res_data.last    = 1'b1;
                            res_push         = !res_full;
                            cmd_pop          = !res_full;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                issue = 1'b1;
            end
            BK_PUSH:
            begin
                res_push = !res_full;
                col_done = !res_full;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            row_reg    <= '0;
            nk_reg     <= '0;
            nc_reg     <= '0;
            k_reg      <= '0;
            j_reg      <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            if (start)
            begin
                row_reg <= cmd.row;
                nk_reg  <= nk_eff;
                nc_reg  <= nc_eff;
                k_reg   <= '0;
                j_reg   <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
            else if (col_done)
            begin
                k_reg <= '0;
                j_reg <= j_reg + CNT_W'(1);
            end
        end
    end

    // multiply-accumulate pipeline: read, product, accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= a_rd_reg * b_rd_reg;
        if (start || col_done)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[wr_addr] <= elem;
        end
        a_rd_reg <= a_mem[a_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[wr_addr] <= elem;
        end
        b_rd_reg <= b_mem[b_rd_addr];
    end

endmodule

// ===== hw/rtl/mme_checker.sv =====
module mme_assert
    import mme_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic pop,
    input logic empty,
    input res_t res
);

    // a waiting result does not change until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(res))
        else $error("result changed while stalled");

    // row error beat is a lone marked zero at column zero
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && res.status |-> res.last && res.out_col == 4'd0 && res.result == 16'sd0)
        else $error("malformed row error beat");

    // columns of one row come out in order
    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !res.last |=> empty ||
            (res.out_row == $past(res.out_row) && res.out_col == $past(res.out_col) + 4'd1))
        else $error("column order broken within a row");

    // a new row starts at column zero
    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && res.last |=> empty || res.out_col == 4'd0)
        else $error("row did not start at column zero");

endmodule

bind matrix_multiply_engine mme_assert u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .pop   (pop),
    .empty (empty),
    .res   (res)
);

// ===== dv/mme_checker.sv =====
module mme_checker
    import mme_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic                  push,
    input  item_t                 item,
    input  logic                  full,
    input  logic                  pop,
    input  res_t                  res,
    input  logic                  empty,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   DIM        = 16;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_ROW_ERR = 1'b1;

    logic signed [15:0]    a_mat [DIM][DIM];
    logic signed [15:0]    b_mat [DIM][DIM];
    logic [CFG_DATA_W-1:0] n_rows;
    logic [CFG_DATA_W-1:0] n_inner;
    logic [CFG_DATA_W-1:0] n_cols;
    res_t                  product_q [$];
    int                    fails;

    // register values above the array size act as the full size
    function automatic int eff_dim(input logic [CFG_DATA_W-1:0] r);
        return (r > DIM) ? DIM : int'(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        int                 nr;
        int                 nk;
        int                 nc;
        int                 j;
        int                 k;
        logic signed [47:0] acc;
        logic signed [47:0] q;
        res_t               want;
        if (!rst_n)
        begin
            n_rows  = CFG_DIM_RESET;
            n_inner = CFG_DIM_RESET;
            n_cols  = CFG_DIM_RESET;
            product_q.delete();
            fails   = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    CFG_ROWS_A:    n_rows  = wr_data;
                    CFG_INNER_LEN: n_inner = wr_data;
                    CFG_COLS_B:    n_cols  = wr_data;
                    default: ;
                endcase
            end
            nr = eff_dim(n_rows);
            nk = eff_dim(n_inner);
            nc = eff_dim(n_cols);

            if (push && !full)
            begin
                case (item.action)
                    ACT_LOAD_A: a_mat[item.row][item.col] = item.value;
                    ACT_LOAD_B: b_mat[item.row][item.col] = item.value;
                    ACT_COMPUTE:
                    begin
                        if (item.row >= nr)
                        begin
                            product_q.push_back(res_t'{item.row, 4'd0, 16'sd0, ST_ROW_ERR, 1'b1});
                        end
                        else
                        begin
                            for (j = 0; j < nc; j++)
                            begin
                                acc = '0;
                                for (k = 0; k < nk; k++)
                                    acc = acc + a_mat[item.row][k] * b_mat[k][j];
                                // round half up, then clamp to q4.12
                                q = (acc + RND_HALF) >>> FRAC_BITS;
                                if (q > RESULT_MAX)
                                    q = RESULT_MAX;
                                else if (q < RESULT_MIN)
                                    q = RESULT_MIN;
                                product_q.push_back(res_t'{item.row, 4'(j), q[15:0], ST_OK,
                                                           j == nc - 1});
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (pop && !empty)
            begin
                if (product_q.size() == 0)
                begin
                    $error("result beat with nothing expected: out_row %0d out_col %0d",
                           res.out_row, res.out_col);
                    fails++;
                end
                else
                begin
                    want = product_q.pop_front();
                    if (res.out_row !== want.out_row)
                    begin
                        $error("out_row: expected %0d, actual %0d", want.out_row, res.out_row);
                        fails++;
                    end
                    if (res.out_col !== want.out_col)
                    begin
                        $error("out_col: expected %0d, actual %0d", want.out_col, res.out_col);
                        fails++;
                    end
                    if (res.result !== want.result)
                    begin
                        $error("result: expected %0d, actual %0d", want.result, res.result);
                        fails++;
                    end
                    if (res.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, res.status);
                        fails++;
                    end
                    if (res.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, res.last);
                        fails++;
                    end
                end
            end
            errors  <= fails;
            pending <= product_q.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    import mme_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   DIM          = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;
    localparam logic [1:0]           ACT_NONE     = 2'd3;
    localparam int                   SETTLE       = 400;
    localparam int                   HOLD_CYCLES  = 600;
    localparam int                   CYCLE_LIMIT  = 400000;
    localparam int                   RANDOM_ITEMS = 280;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    logic                  push;
    item_t                 item;
    logic                  full;
    logic                  pop;
    res_t                  res;
    logic                  empty;

    int errors;
    int pending;
    int cycles;
    int issued;
    int er;
    int ek;
    int ec;
    bit a_set [DIM][DIM];
    bit b_set [DIM][DIM];
    bit quiet;
    bit hold_rx;
    bit held;

    matrix_multiply_engine DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .item     (item),
        .full     (full),
        .pop      (pop),
        .res      (res),
        .empty    (empty)
    );

    mme_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .item     (item),
        .full     (full),
        .pop      (pop),
        .res      (res),
        .empty    (empty),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random pops, one long hold-off when asked
    initial
    begin
        pop <= 1'b0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx && !held)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1;
            end
            pop <= quiet || ($urandom_range(0, 99) >= 26);
        end
    end

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1:
            begin
                case ($urandom_range(0, 5))
                    0:       return 16'sh7fff;
                    1:       return 16'sh8000;
                    2:       return 16'sd0;
                    3:       return 16'sd2048;
                    4:       return -16'sd2048;
                    default: return -16'sd1;
                endcase
            end
            default: return 16'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    task automatic issue_item(input logic [1:0] act, input logic [3:0] r, input logic [3:0] c,
                              input logic signed [15:0] v);
        while (!quiet && $urandom_range(0, 99) < 26)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= item_t'{act, r, c, v};
        @(posedge clk);
        while (full) @(posedge clk);
        if (act != ACT_NONE)
            issued++;
    endtask

    task automatic load_elem(input logic [1:0] act, input int r, input int c,
                             input logic signed [15:0] v);
        if (act == ACT_LOAD_A)
            a_set[r][c] = 1;
        else
            b_set[r][c] = 1;
        issue_item(act, 4'(r), 4'(c), v);
    endtask

    // fill whatever the row still needs so no unwritten element is ever read
    task automatic compute_row(input int r);
        int k;
        int j;
        if (r < er)
        begin
            for (k = 0; k < ek; k++)
                if (!a_set[r][k])
                    load_elem(ACT_LOAD_A, r, k, rand_value());
            for (k = 0; k < ek; k++)
                for (j = 0; j < ec; j++)
                    if (!b_set[k][j])
                        load_elem(ACT_LOAD_B, k, j, rand_value());
        end
        issue_item(ACT_COMPUTE, 4'(r), 4'($urandom), 16'($urandom));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= d;
        @(posedge clk);
    endtask

    task automatic set_dims(input int r, input int k, input int c);
        cfg_write(CFG_ROWS_A, 5'(r));
        cfg_write(CFG_INNER_LEN, 5'(k));
        cfg_write(CFG_COLS_B, 5'(c));
        cfg_write(CFG_UNUSED, 5'($urandom));
        wr_en <= 1'b0;
        er = (r > DIM) ? DIM : r;
        ek = (k > DIM) ? DIM : k;
        ec = (c > DIM) ? DIM : c;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // loads and empty computes leave no beat behind, give them time
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int compute_pct);
        int         i;
        int         pick;
        int         r;
        int         c;
        logic [1:0] act;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < compute_pct)
            begin
                if (er > 0 && $urandom_range(0, 3) != 0)
                    compute_row($urandom_range(0, er - 1));
                else
                    compute_row($urandom_range(0, DIM - 1));
            end
            else if (pick < 97)
            begin
                act = $urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A;
                r = $urandom_range(0, DIM - 1);
                c = $urandom_range(0, DIM - 1);
                // mostly overwrite elements the current shape actually uses
                if ($urandom_range(0, 4) < 3)
                begin
                    if (act == ACT_LOAD_A)
                    begin
                        if (er > 0) r = $urandom_range(0, er - 1);
                        if (ek > 0) c = $urandom_range(0, ek - 1);
                    end
                    else
                    begin
                        if (ek > 0) r = $urandom_range(0, ek - 1);
                        if (ec > 0) c = $urandom_range(0, ec - 1);
                    end
                end
                load_elem(act, r, c, rand_value());
            end
            else
            begin
                issue_item(ACT_NONE, 4'($urandom), 4'($urandom), 16'($urandom));
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        wr_en    <= 1'b0;
        wr_index <= '0;
        wr_data  <= '0;
        push     <= 1'b0;
        item     <= '0;
        quiet   = 0;
        hold_rx = 0;
        issued  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturation both ways, a rounding tie, corner addresses, bad rows
        set_dims(3, 2, 2);
        load_elem(ACT_LOAD_A, 0, 0, 16'sh7fff);
        load_elem(ACT_LOAD_A, 0, 1, 16'sh7fff);
        load_elem(ACT_LOAD_A, 1, 0, 16'sh8000);
        load_elem(ACT_LOAD_A, 1, 1, 16'sh8000);
        load_elem(ACT_LOAD_A, 2, 0, 16'sd1);
        load_elem(ACT_LOAD_A, 2, 1, 16'sd0);
        load_elem(ACT_LOAD_B, 0, 0, 16'sh7fff);
        load_elem(ACT_LOAD_B, 1, 0, 16'sh7fff);
        load_elem(ACT_LOAD_B, 0, 1, 16'sd2048);
        load_elem(ACT_LOAD_B, 1, 1, -16'sd1);
        load_elem(ACT_LOAD_A, 15, 15, -16'sd1);
        load_elem(ACT_LOAD_B, 15, 15, 16'sd0);
        compute_row(0);
        compute_row(1);
        compute_row(2);
        compute_row(3);
        compute_row(15);
        issue_item(ACT_NONE, 4'hf, 4'hf, 16'shffff);
        drain();

        set_dims(0, 4, 4);
        run_phase(15, 50);
        set_dims(4, 0, 4);
        run_phase(15, 40);
        set_dims(4, 4, 0);
        run_phase(15, 40);
        set_dims(31, 4, 1);
        run_phase(15, 30);
        set_dims(16, 1, 31);
        run_phase(15, 30);
        set_dims(1, 17, 2);
        run_phase(15, 30);
        set_dims(1, 1, 1);
        run_phase(15, 40);

        // receiver stalls while computes pile up behind it
        set_dims(3, 2, 3);
        hold_rx = 1;
        run_phase(30, 90);

        quiet = 1;
        set_dims($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 5));
        run_phase(25, 35);
        quiet = 0;

        while (issued < RANDOM_ITEMS)
        begin
            set_dims($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 5));
            run_phase(25, 35);
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== matrix_multiply_engine.f =====
hw/rtl/mme_pkg.sv
hw/rtl/mme_fifo.sv
hw/rtl/mme_front.sv
hw/rtl/mme_back.sv
hw/rtl/matrix_multiply_engine.sv
hw/rtl/mme_checker.sv
dv/mme_checker.sv
dv/tb.sv
